// ===== rtl/cil_pkg.sv =====
// shared constants for the compacting identifier list
// operation and status codes, field widths and the default store size
// no dependencies
package cil_pkg;

  localparam int DEF_CAPACITY = 128;

  localparam int DATA_W   = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;
  localparam int COUNT_W  = 8;

  // operation codes
  localparam logic [KIND_W-1:0] K_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] K_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] K_SEARCH = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

endpackage

// ===== rtl/compacting_id_list_unit.sv =====
// Unsorted list of 32-bit identifiers packed from position 0 of a single-port-read
// entry store, with a fill count. Take an item when start is high and busy is low;
// its result appears for exactly one cycle with out_valid and cannot be held off.
// An add is answered from the idle state and leaves busy low. A search walks the
// entries through the store's single read port, one a cycle, and reports at its first
// match or after the last held entry. A delete walks to its first match and then moves
// every later entry down by one, read and write back one a cycle; a miss reports
// after the last held entry. For a search or delete on a non-empty store, busy stays
// high from the cycle after the item is taken until its result is shown;
// the next item may be taken in the cycle that shows the result.
module compacting_id_list_unit #(
  parameter int CAPACITY = cil_pkg::DEF_CAPACITY
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [cil_pkg::KIND_W-1:0]          in_kind,
  input  logic signed [cil_pkg::DATA_W-1:0]   in_item_id,
  output logic                                out_valid,
  output logic [cil_pkg::STATUS_W-1:0]        out_status,
  output logic [cil_pkg::POS_W-1:0]           out_position,
  output logic [cil_pkg::COUNT_W-1:0]         out_fill_count
);
  import cil_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT} state_t;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [DATA_W-1:0]   key_r, key_nxt;
  logic                del_r, del_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [POS_W-1:0]    out_position_r, out_position_nxt;
  logic [COUNT_W-1:0]  out_fill_count_r, out_fill_count_nxt;

  logic                wr_en;
  logic [IDX_W-1:0]    wr_addr;
  logic [DATA_W-1:0]   wr_data;
  logic [IDX_W-1:0]    rd_addr;
  logic [DATA_W-1:0]   rd_data;

  logic [CNT_W-1:0]    idx_ext;
  logic                scan_last;
  logic                shift_last;
  logic                full;

  assign idx_ext    = CNT_W'(idx_r);
  assign scan_last  = (idx_ext + CNT_W'(1)) == used_r;
  assign shift_last = (idx_ext + CNT_W'(2)) == used_r;
  assign full       = used_r >= CNT_W'(CAPACITY);

  cil_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt          = state_r;
    idx_nxt            = idx_r;
    pos_nxt            = pos_r;
    used_nxt           = used_r;
    key_nxt            = key_r;
    del_nxt            = del_r;
    out_valid_nxt      = 1'b0;
    out_status_nxt     = out_status_r;
    out_position_nxt   = out_position_r;
    out_fill_count_nxt = out_fill_count_r;
    wr_en              = 1'b0;
    wr_addr            = idx_r;
    wr_data            = rd_data;
    rd_addr            = '0;

    unique case (state_r)
      S_IDLE: begin
        // entry 0 is read ahead so rd_data holds it when a scan begins
        rd_addr = '0;
        if (start) begin
          key_nxt = in_item_id;
          del_nxt = (in_kind == K_DELETE);
          idx_nxt = '0;
          unique case (in_kind) inside
            K_ADD: begin
              out_valid_nxt    = 1'b1;
              out_position_nxt = '0;
              if (full) begin
                out_status_nxt     = ST_FULL;
                out_fill_count_nxt = COUNT_W'(used_r);
              end else begin
                wr_en              = 1'b1;
                wr_addr            = IDX_W'(used_r);
                wr_data            = in_item_id;
                used_nxt           = used_r + CNT_W'(1);
                out_status_nxt     = ST_OK;
                out_fill_count_nxt = COUNT_W'(used_r + CNT_W'(1));
              end
            end
            K_DELETE, K_SEARCH: begin
              if (used_r == '0) begin
                out_valid_nxt      = 1'b1;
                out_status_nxt     = ST_NOT_FOUND;
                out_position_nxt   = '0;
                out_fill_count_nxt = COUNT_W'(used_r);
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              out_valid_nxt      = 1'b1;
              out_status_nxt     = ST_NOT_FOUND;
              out_position_nxt   = '0;
              out_fill_count_nxt = COUNT_W'(used_r);
            end
          endcase
        end
      end

      S_SCAN: begin
        // rd_data holds entry idx_r, the next one is already on its way
        rd_addr = idx_r + IDX_W'(1);
        if (rd_data == key_r) begin
          pos_nxt = idx_r;
          if (!del_r) begin
            state_nxt          = S_IDLE;
            out_valid_nxt      = 1'b1;
            out_status_nxt     = ST_OK;
            out_position_nxt   = POS_W'(idx_r);
            out_fill_count_nxt = COUNT_W'(used_r);
          end else if (scan_last) begin
            // match in the last entry, nothing to move down
            state_nxt          = S_IDLE;
            used_nxt           = used_r - CNT_W'(1);
            out_valid_nxt      = 1'b1;
            out_status_nxt     = ST_OK;
            out_position_nxt   = POS_W'(idx_r);
            out_fill_count_nxt = COUNT_W'(used_r - CNT_W'(1));
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (scan_last) begin
          state_nxt          = S_IDLE;
          out_valid_nxt      = 1'b1;
          out_status_nxt     = ST_NOT_FOUND;
          out_position_nxt   = '0;
          out_fill_count_nxt = COUNT_W'(used_r);
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_SHIFT: begin
        // rd_data holds entry idx_r + 1, written back one place down
        rd_addr = idx_r + IDX_W'(2);
        wr_en   = 1'b1;
        wr_addr = idx_r;
        wr_data = rd_data;
        if (shift_last) begin
          state_nxt          = S_IDLE;
          used_nxt           = used_r - CNT_W'(1);
          out_valid_nxt      = 1'b1;
          out_status_nxt     = ST_OK;
          out_position_nxt   = POS_W'(pos_r);
          out_fill_count_nxt = COUNT_W'(used_r - CNT_W'(1));
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r            <= idx_nxt;
    pos_r            <= pos_nxt;
    key_r            <= key_nxt;
    del_r            <= del_nxt;
    out_status_r     <= out_status_nxt;
    out_position_r   <= out_position_nxt;
    out_fill_count_r <= out_fill_count_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_position   = out_position_r;
  assign out_fill_count = out_fill_count_r;

endmodule

// ===== rtl/cil_mem.sv =====
// entry store of the compacting identifier list
// one write port and one read port, read data registered
// depends on cil_pkg
module cil_mem #(
  parameter int DEPTH  = cil_pkg::DEF_CAPACITY,
  parameter int ADDR_W = 7
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [ADDR_W-1:0]          wr_addr,
  input  logic [cil_pkg::DATA_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]          rd_addr,
  output logic [cil_pkg::DATA_W-1:0] rd_data
);
  import cil_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== tb/sv/cil_list_checker.sv =====
// result checker for the compacting identifier list unit
// keeps its own copy of the identifier store, predicts each result and compares
// depends on cil_pkg for widths, operation and status codes
`timescale 1ns / 1ps

module cil_list_checker #(
  parameter int CAPACITY = cil_pkg::DEF_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic [cil_pkg::KIND_W-1:0]        in_kind,
  input  logic signed [cil_pkg::DATA_W-1:0] in_item_id,
  input  logic                              out_valid,
  input  logic [cil_pkg::STATUS_W-1:0]      out_status,
  input  logic [cil_pkg::POS_W-1:0]         out_position,
  input  logic [cil_pkg::COUNT_W-1:0]       out_fill_count,
  output int                                err_count,
  output int                                pending,
  output int                                checked,
  output int                                full_seen,
  output int                                misses_seen,
  output int                                peak_fill
);
  import cil_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  fill_count;
  } id_list_result_t;

  logic [DATA_W-1:0] held_ids [CAPACITY];
  int                held_count = 0;
  id_list_result_t   expected_results [$];
  int                errs = 0;
  int                n_checked = 0;
  int                n_full = 0;
  int                n_miss = 0;
  int                n_peak = 0;

  initial begin
    err_count   = 0;
    pending     = 0;
    checked     = 0;
    full_seen   = 0;
    misses_seen = 0;
    peak_fill   = 0;
  end

  // applies one request to the local store and returns what the unit should answer
  function automatic id_list_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                    input logic [DATA_W-1:0] key);
    id_list_result_t r;
    int hit;
    hit        = -1;
    r.status   = ST_NOT_FOUND;
    r.position = '0;
    for (int i = 0; i < held_count; i++)
      if (hit < 0 && held_ids[i] == key) hit = i;
    case (kind)
      K_ADD: begin
        if (held_count >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          held_ids[held_count] = key;
          held_count++;
          r.status = ST_OK;
        end
      end
      K_DELETE: begin
        if (hit >= 0) begin
          // close the gap left by the removed entry
          for (int i = hit; i + 1 < held_count; i++) held_ids[i] = held_ids[i + 1];
          held_count--;
          r.status   = ST_OK;
          r.position = hit[POS_W-1:0];
        end
      end
      K_SEARCH: begin
        if (hit >= 0) begin
          r.status   = ST_OK;
          r.position = hit[POS_W-1:0];
        end
      end
      default: begin
      end
    endcase
    r.fill_count = held_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    id_list_result_t want_r;
    if (!rst_n) begin
      held_count = 0;
      expected_results.delete();
    end else begin
      // the result leaving now belongs to an earlier item than one taken now
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, status %0d position %0d count %0d",
                   $time, out_status, out_position, out_fill_count);
          errs++;
        end else begin
          want_r = expected_results.pop_front();
          check_field("status", want_r.status, out_status);
          check_field("position", want_r.position, out_position);
          check_field("fill_count", want_r.fill_count, out_fill_count);
          n_checked++;
          if (want_r.status == ST_FULL) n_full++;
          if (want_r.status == ST_NOT_FOUND) n_miss++;
        end
      end
      if (start && !busy) begin
        expected_results.push_back(apply_request(in_kind, in_item_id));
        if (held_count > n_peak) n_peak = held_count;
      end
    end
    err_count   <= errs;
    pending     <= expected_results.size();
    checked     <= n_checked;
    full_seen   <= n_full;
    misses_seen <= n_miss;
    peak_fill   <= n_peak;
  end

endmodule

// ===== tb/sv/tb_compacting_id_list_unit.sv =====
// top level testbench for compacting_id_list_unit
// drives directed then random add, delete, search and unused-kind items, checked
// in cil_list_checker; depends on cil_pkg, compacting_id_list_unit and cil_list_checker
`timescale 1ns / 1ps

module tb_compacting_id_list_unit;
  import cil_pkg::*;

  localparam logic [KIND_W-1:0] K_UNUSED = 2'd3;
  localparam int CAPACITY     = DEF_CAPACITY;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_ITEMS = 550;
  localparam int DRAIN_CYCLES = 2 * CAPACITY + 20;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     start = 1'b0;
  logic                     busy;
  logic [KIND_W-1:0]        in_kind = K_ADD;
  logic signed [DATA_W-1:0] in_item_id = '0;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic [POS_W-1:0]         out_position;
  logic [COUNT_W-1:0]       out_fill_count;

  int err_count, pending, checked, full_seen, misses_seen, peak_fill;
  int cycles = 0;
  int sent = 0;
  int directed = 0;
  int idle_pct = 0;

  // identifiers believed to be held, used only to steer the stimulus towards hits
  logic [DATA_W-1:0] issued_ids [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  compacting_id_list_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_item_id     (in_item_id),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_position   (out_position),
    .out_fill_count (out_fill_count)
  );

  cil_list_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_item_id     (in_item_id),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_position   (out_position),
    .out_fill_count (out_fill_count),
    .err_count      (err_count),
    .pending        (pending),
    .checked        (checked),
    .full_seen      (full_seen),
    .misses_seen    (misses_seen),
    .peak_fill      (peak_fill)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic issue(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] key);
    int idx;
    idx = -1;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start      <= 1'b1;
    in_kind    <= kind;
    in_item_id <= key;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (kind == K_ADD && issued_ids.size() < CAPACITY) issued_ids.push_back(key);
    if (kind == K_DELETE) begin
      foreach (issued_ids[i])
        if (idx < 0 && issued_ids[i] == key) idx = i;
      if (idx >= 0) issued_ids.delete(idx);
    end
  endtask

  // half from a small hot set so that duplicates build up, half fully random
  function automatic logic [DATA_W-1:0] pick_key();
    if ($urandom_range(1) == 0) return $urandom();
    case ($urandom_range(7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0000_0001;
      5:       return 32'h5555_5555;
      6:       return 32'hAAAA_AAAA;
      default: return 32'h0000_00C3;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] held_key();
    if (issued_ids.size() == 0) return pick_key();
    return issued_ids[$urandom_range(issued_ids.size() - 1)];
  endfunction

  initial begin
    int  roll;
    bit  shrinking;
    shrinking = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store, extremes, duplicates, compaction and the unused kind
    issue(K_SEARCH, 32'h0000_0000);
    issue(K_DELETE, 32'h0000_0005);
    issue(K_UNUSED, 32'h0000_0000);
    issue(K_ADD,    32'h8000_0000);
    issue(K_ADD,    32'h7FFF_FFFF);
    issue(K_ADD,    32'h0000_0000);
    issue(K_ADD,    32'hFFFF_FFFF);
    issue(K_ADD,    32'h7FFF_FFFF);
    issue(K_ADD,    32'h1234_5678);
    issue(K_SEARCH, 32'h7FFF_FFFF);
    issue(K_SEARCH, 32'hFFFF_FFFF);
    issue(K_SEARCH, 32'h0000_0001);
    issue(K_SEARCH, 32'h8000_0000);
    issue(K_DELETE, 32'h7FFF_FFFF);
    issue(K_SEARCH, 32'h7FFF_FFFF);
    issue(K_DELETE, 32'h1234_5678);
    issue(K_DELETE, 32'h8000_0000);
    issue(K_UNUSED, 32'h7FFF_FFFF);
    issue(K_DELETE, 32'hFFFF_FFFE);
    issue(K_SEARCH, 32'h0000_0000);
    issue(K_SEARCH, 32'h7FFF_FFFF);
    directed = sent;

    // grow to capacity, knock on the full store, drain back down, repeat
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      idle_pct = (n < 140) ? 0 : (n < 280) ? 71 : (n < 420) ? 27 : 0;
      roll = $urandom_range(99);
      if (issued_ids.size() >= CAPACITY && $urandom_range(3) == 0) shrinking = 1'b1;
      if (issued_ids.size() <= 2) shrinking = 1'b0;
      if (!shrinking) begin
        if (roll < 70)      issue(K_ADD, pick_key());
        else if (roll < 80) issue(K_SEARCH, held_key());
        else if (roll < 85) issue(K_SEARCH, $urandom());
        else if (roll < 95) issue(K_DELETE, held_key());
        else if (roll < 98) issue(K_DELETE, $urandom());
        else                issue(K_UNUSED, pick_key());
      end else begin
        if (roll < 60)      issue(K_DELETE, held_key());
        else if (roll < 68) issue(K_DELETE, $urandom());
        else if (roll < 83) issue(K_SEARCH, held_key());
        else if (roll < 88) issue(K_SEARCH, $urandom());
        else if (roll < 98) issue(K_ADD, pick_key());
        else                issue(K_UNUSED, pick_key());
      end
    end
    start <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d items sent (%0d directed), %0d results checked", sent, directed, checked);
    $display("store filled to %0d of %0d, %0d full answers, %0d not-found answers",
             peak_fill, CAPACITY, full_seen, misses_seen);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cil_pkg.sv
rtl/cil_mem.sv
rtl/compacting_id_list_unit.sv
tb/sv/cil_list_checker.sv
tb/sv/tb_compacting_id_list_unit.sv
